// File: rtl/slc_pkg.sv
package slc_pkg;

	typedef enum logic [3:0] {
		KIND_UNKNOWN  = 4'd0,
		KIND_IDENT    = 4'd1,
		KIND_NUMBER   = 4'd2,
		KIND_OPERATOR = 4'd3,
		KIND_LBRACE   = 4'd4,
		KIND_RBRACE   = 4'd5,
		KIND_LPAREN   = 4'd6,
		KIND_RPAREN   = 4'd7,
		KIND_COMMA    = 4'd8,
		KIND_KW_IF    = 4'd9,
		KIND_KW_ELSE  = 4'd10,
		KIND_KW_FUNC  = 4'd11,
		KIND_KW_RET   = 4'd12,
		KIND_KW_TRUE  = 4'd13,
		KIND_KW_FALSE = 4'd14
	} tok_kind_t;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_DOT    = 8'h2E;

	localparam int NUM_KW = 6;

	// Keyword text, character i in byte i.
	localparam logic [63:0] KW_TEXT [NUM_KW] = '{
		64'h0000_0000_0000_6669,
		64'h0000_0000_6573_6C65,
		64'h6E6F_6974_636E_7566,
		64'h0000_6E72_7574_6572,
		64'h0000_0000_6575_7274,
		64'h0000_0065_736C_6166
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd2, 4'd4, 4'd8, 4'd6, 4'd4, 4'd5};

	typedef enum logic [5:0] {
		CL_EMPTY = 6'b000001,
		CL_IDENT = 6'b000010,
		CL_INT   = 6'b000100,
		CL_DOT   = 6'b001000,
		CL_FRAC  = 6'b010000,
		CL_BAD   = 6'b100000
	} word_class_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [7:0]  length;
		logic [7:0]  delim;
		logic [15:0] line;
		logic [11:0] col;
	} tok_t;

	typedef struct packed {
		logic two;
		tok_t t0;
		tok_t t1;
	} entry_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	function automatic logic is_delim(logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
			c == CH_LPAREN || c == CH_RPAREN || c == CH_SPACE || c == CH_COMMA ||
			c == CH_NL || c == CH_SEMI || c == CH_LBRACE || c == CH_RBRACE ||
			c == CH_LT || c == CH_GT;
	endfunction

	function automatic tok_kind_t delim_kind(logic [7:0] c);
		tok_kind_t k;
		k = KIND_UNKNOWN;
		case (c)
			CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LT, CH_GT: k = KIND_OPERATOR;
			CH_LBRACE: k = KIND_LBRACE;
			CH_RBRACE: k = KIND_RBRACE;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_COMMA:  k = KIND_COMMA;
			default:   k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/slc_ifs.sv
interface slc_char_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] char_code;

	modport source (output valid, req_type, char_code, input ready);
	modport sink (input valid, req_type, char_code, output ready);
endinterface

interface slc_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [7:0]  token_length;
	logic [7:0]  delimiter_code;
	logic [15:0] line_number;
	logic [11:0] column_number;
	logic        last_of_run;

	modport source (output valid, token_kind, token_length, delimiter_code, line_number,
		column_number, last_of_run, input ready);
	modport sink (input valid, token_kind, token_length, delimiter_code, line_number,
		column_number, last_of_run, output ready);
endinterface

// File: rtl/slc_front.sv
module slc_front
	import slc_pkg::*;
#(
	parameter int LINE_BITS = 16,
	parameter int COLUMN_BITS = 12,
	parameter int MAX_WORD_LENGTH = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] char_code,
	input  logic       q_full,
	output logic       q_push,
	output entry_t     q_entry
);

	localparam int WL_BITS = $clog2(MAX_WORD_LENGTH + 1);

	logic [LINE_BITS-1:0]   line_q, line_n, line_inc;
	logic [COLUMN_BITS-1:0] col_q, col_n, col_inc, slash_col_q, slash_col_n;
	logic [WL_BITS-1:0]     wl_q, wl_n;
	word_class_t            cls_q, cls_n, cls_add;
	logic [NUM_KW-1:0]      cand_q, cand_n, cand_add;
	logic                   comment_q, comment_n, slash_q, slash_n;

	logic       accept;
	logic       alpha, digit, nl;
	logic [15:0] line_sat, line_inc_sat;
	logic [11:0] col_sat, slash_col_sat;
	logic [7:0] wl_sat;
	tok_kind_t  word_kind;
	tok_t       tok_a, tok_b, tok_c;
	logic       va, vb, vc;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign nl = char_code == CH_NL;
	assign alpha = (char_code >= 8'h61 && char_code <= 8'h7A) ||
		(char_code >= 8'h41 && char_code <= 8'h5A);
	assign digit = char_code >= 8'h30 && char_code <= 8'h39;

	assign line_inc = (line_q != '1) ? line_q + 1'b1 : line_q;
	assign col_inc = (col_q != '1) ? col_q + 1'b1 : col_q;

	assign line_sat = (32'(line_q) > 32'hFFFF) ? 16'hFFFF : 16'(line_q);
	assign line_inc_sat = (32'(line_inc) > 32'hFFFF) ? 16'hFFFF : 16'(line_inc);
	assign col_sat = (32'(col_q) > 32'hFFF) ? 12'hFFF : 12'(col_q);
	assign slash_col_sat = (32'(slash_col_q) > 32'hFFF) ? 12'hFFF : 12'(slash_col_q);
	assign wl_sat = (32'(wl_q) > 32'd255) ? 8'hFF : 8'(wl_q);

	// A keyword wins when its candidate bit survived and the length is exact.
	always_comb begin
		if (cls_q == CL_IDENT) begin
			word_kind = KIND_IDENT;
		end else if (cls_q == CL_INT || cls_q == CL_FRAC) begin
			word_kind = KIND_NUMBER;
		end else begin
			word_kind = KIND_UNKNOWN;
		end
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (cand_q[k] && 32'(wl_q) == 32'(KW_LEN[k])) begin
				word_kind = tok_kind_t'(4'(32'(KIND_KW_IF) + k));
			end
		end
	end

	always_comb begin
		cand_add = cand_q;
		for (int k = 0; k < NUM_KW; k++) begin
			if (32'(wl_q) >= 32'(KW_LEN[k]) ||
				KW_TEXT[k][{wl_q[2:0], 3'b000} +: 8] != char_code) begin
				cand_add[k] = 1'b0;
			end
		end
		unique case (cls_q) inside
			CL_EMPTY: cls_add = alpha ? CL_IDENT : (digit ? CL_INT : CL_BAD);
			CL_IDENT: cls_add = (alpha || digit) ? CL_IDENT : CL_BAD;
			CL_INT: cls_add = digit ? CL_INT : ((char_code == CH_DOT) ? CL_DOT : CL_BAD);
			CL_DOT, CL_FRAC: cls_add = digit ? CL_FRAC : CL_BAD;
			default: cls_add = CL_BAD;
		endcase
	end

	// Up to three token slots in order: pending slash, word, delimiter.
	always_comb begin
		line_n = line_q;
		col_n = col_q;
		slash_col_n = slash_col_q;
		wl_n = wl_q;
		cls_n = cls_q;
		cand_n = cand_q;
		comment_n = comment_q;
		slash_n = slash_q;
		va = 1'b0;
		vb = 1'b0;
		vc = 1'b0;
		tok_a = '{kind: KIND_OPERATOR, length: 8'd1, delim: CH_SLASH, line: line_sat,
			col: slash_col_sat};
		tok_b = '{kind: word_kind, length: wl_sat, delim: 8'd0, line: line_sat, col: col_sat};
		tok_c = '{kind: delim_kind(char_code), length: 8'd1, delim: char_code,
			line: line_sat, col: col_sat};
		if (req_type) begin
			va = slash_q;
			vb = !slash_q && cls_q != CL_EMPTY;
			line_n = '0;
			col_n = '0;
			slash_col_n = '0;
			wl_n = '0;
			cls_n = CL_EMPTY;
			cand_n = '1;
			comment_n = 1'b0;
			slash_n = 1'b0;
		end else if (comment_q) begin
			if (nl) begin
				comment_n = 1'b0;
				line_n = line_inc;
				col_n = '0;
			end else begin
				col_n = col_inc;
			end
		end else if (slash_q && char_code == CH_SLASH) begin
			slash_n = 1'b0;
			comment_n = 1'b1;
			col_n = col_inc;
		end else begin
			va = slash_q;
			slash_n = 1'b0;
			if (nl || char_code == CH_SLASH || is_delim(char_code)) begin
				vb = cls_q != CL_EMPTY;
				wl_n = '0;
				cls_n = CL_EMPTY;
				cand_n = '1;
				if (nl) begin
					line_n = line_inc;
					col_n = '0;
					tok_b.line = line_inc_sat;
					tok_b.col = 12'd0;
				end else if (char_code == CH_SLASH) begin
					slash_n = 1'b1;
					slash_col_n = col_q;
					col_n = col_inc;
				end else begin
					vc = char_code != CH_SPACE;
					col_n = col_inc;
				end
			end else begin
				cand_n = cand_add;
				cls_n = cls_add;
				if (32'(wl_q) < 32'(MAX_WORD_LENGTH)) begin
					wl_n = wl_q + 1'b1;
				end
				col_n = col_inc;
			end
		end
	end

	always_comb begin
		q_entry.two = (va && vb) || (va && vc) || (vb && vc);
		q_entry.t0 = va ? tok_a : (vb ? tok_b : tok_c);
		q_entry.t1 = (va && vb) ? tok_b : tok_c;
		q_push = accept && (va || vb || vc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
			col_q <= '0;
			slash_col_q <= '0;
			wl_q <= '0;
			cls_q <= CL_EMPTY;
			cand_q <= '1;
			comment_q <= 1'b0;
			slash_q <= 1'b0;
		end else if (accept) begin
			line_q <= line_n;
			col_q <= col_n;
			slash_col_q <= slash_col_n;
			wl_q <= wl_n;
			cls_q <= cls_n;
			cand_q <= cand_n;
			comment_q <= comment_n;
			slash_q <= slash_n;
		end
	end

	a_comment_slash_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(comment_q && slash_q))
		else $error("comment and pending slash both set");

	a_empty_word_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cls_q == CL_EMPTY) |-> (wl_q == '0 && cand_q == '1))
		else $error("empty word carries length or cleared candidates");

endmodule

// File: rtl/slc_queue.sv
module slc_queue
	import slc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output entry_t head,
	output logic   empty
);

	entry_t                mem [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_q, rd_q;
	logic [QCNT_BITS-1:0]  cnt_q;

	assign full = cnt_q == QCNT_BITS'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into a full token queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from an empty token queue");

endmodule

// File: rtl/slc_back.sv
module slc_back
	import slc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  entry_t head,
	input  logic   empty,
	output logic   pop,
	slc_token_if.source tok
);

	tok_t tok_q;
	logic valid_q, last_q, sec_q;
	logic load;

	assign load = !valid_q || tok.ready;
	assign pop = load && !empty && (sec_q || !head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sec_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				sec_q <= !sec_q && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			tok_q <= sec_q ? head.t1 : head.t0;
			last_q <= sec_q || !head.two;
		end
	end

	assign tok.valid = valid_q;
	assign tok.token_kind = tok_q.kind;
	assign tok.token_length = tok_q.length;
	assign tok.delimiter_code = tok_q.delim;
	assign tok.line_number = tok_q.line;
	assign tok.column_number = tok_q.col;
	assign tok.last_of_run = last_q;

	a_second_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q |-> (!empty && head.two))
		else $error("second token pending without a two-token entry");

endmodule

// File: rtl/script_lexer_token_classifier_unit.sv
// Channel | Dir | Fields
// src     | in  | req_type, char_code
// tok     | out | token_kind, token_length, delimiter_code, line_number,
//         |     | column_number, last_of_run
//
// One character is taken per cycle while the queue has room; its tokens are queued and
// then registered. An input that makes two tokens holds the output register for both in turn,
// so the next input is taken back to back until the two-entry token queue fills.
// Reset is asynchronous and clears the lexer state, queue pointers and output valid.
// A stalled output fills the queue and then drops src.ready.
module script_lexer_token_classifier_unit
	import slc_pkg::*;
#(
	parameter int LINE_BITS = 16,
	parameter int COLUMN_BITS = 12,
	parameter int MAX_WORD_LENGTH = 255
) (
	input  logic clk,
	input  logic arst_n,
	slc_char_if.sink src,
	slc_token_if.source tok
);

	logic   q_full, q_push, q_pop, q_empty;
	entry_t q_entry, q_head;

	slc_front #(
		.LINE_BITS(LINE_BITS),
		.COLUMN_BITS(COLUMN_BITS),
		.MAX_WORD_LENGTH(MAX_WORD_LENGTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(src.valid),
		.in_ready(src.ready),
		.req_type(src.req_type),
		.char_code(src.char_code),
		.q_full(q_full),
		.q_push(q_push),
		.q_entry(q_entry)
	);

	slc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_entry(q_entry),
		.full(q_full),
		.pop(q_pop),
		.head(q_head),
		.empty(q_empty)
	);

	slc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(q_head),
		.empty(q_empty),
		.pop(q_pop),
		.tok(tok)
	);

endmodule

// File: tb/slc_token_checker.sv
module slc_token_checker
	import slc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  char_code,
	input  logic        tok_valid,
	input  logic        tok_ready,
	input  logic [3:0]  token_kind,
	input  logic [7:0]  token_length,
	input  logic [7:0]  delimiter_code,
	input  logic [15:0] line_number,
	input  logic [11:0] column_number,
	input  logic        last_of_run,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		tok_t tok;
		logic last;
	} token_exp_t;

	token_exp_t expected_toks[$];

	logic [15:0] line_no;
	logic [11:0] col_no;
	logic [7:0]  word_len;
	word_class_t word_cls;
	logic [5:0]  kw_mask;
	logic        in_cmt;
	logic        slash_wait;
	logic [11:0] slash_col;

	// Tokens made by the character being processed.
	tok_t step_toks[2];
	int   step_n;

	function automatic logic splits_word(logic [7:0] c);
		case (c)
			CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN, CH_SPACE,
			CH_COMMA, CH_NL, CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LT, CH_GT: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic tok_kind_t delim_token_kind(logic [7:0] c);
		case (c)
			CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LT, CH_GT: return KIND_OPERATOR;
			CH_LBRACE: return KIND_LBRACE;
			CH_RBRACE: return KIND_RBRACE;
			CH_LPAREN: return KIND_LPAREN;
			CH_RPAREN: return KIND_RPAREN;
			CH_COMMA:  return KIND_COMMA;
			default:   return KIND_UNKNOWN;
		endcase
	endfunction

	function void add_tok(tok_kind_t kind, logic [7:0] len, logic [7:0] delim,
		logic [15:0] line, logic [11:0] col);
		step_toks[step_n] = '{kind: kind, length: len, delim: delim, line: line, col: col};
		step_n++;
	endfunction

	function void clear_word();
		word_len = 8'd0;
		word_cls = CL_EMPTY;
		kw_mask = '1;
	endfunction

	function void reset_lexer();
		line_no = '0;
		col_no = '0;
		clear_word();
		in_cmt = 1'b0;
		slash_wait = 1'b0;
		slash_col = '0;
	endfunction

	function void bump_col();
		if (col_no != '1) begin
			col_no++;
		end
	endfunction

	function void bump_line();
		if (line_no != '1) begin
			line_no++;
		end
		col_no = '0;
	endfunction

	function void flush_word(logic [11:0] col);
		tok_kind_t kind;
		kind = KIND_UNKNOWN;
		if (word_cls == CL_EMPTY) begin
			return;
		end
		// Walk downward so that the first keyword in table order wins.
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (kw_mask[k] && word_len == 8'(KW_LEN[k])) begin
				kind = tok_kind_t'(KIND_KW_IF + k);
			end
		end
		if (kind == KIND_UNKNOWN) begin
			if (word_cls == CL_IDENT) begin
				kind = KIND_IDENT;
			end else if (word_cls == CL_INT || word_cls == CL_FRAC) begin
				kind = KIND_NUMBER;
			end
		end
		add_tok(kind, word_len, 8'd0, line_no, col);
		clear_word();
	endfunction

	function void take_char(logic [7:0] c);
		logic alpha;
		logic digit;
		alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		digit = c >= "0" && c <= "9";
		for (int k = 0; k < NUM_KW; k++) begin
			if (word_len >= 8'(KW_LEN[k])) begin
				kw_mask[k] = 1'b0;
			end else if (KW_TEXT[k][8 * word_len +: 8] != c) begin
				kw_mask[k] = 1'b0;
			end
		end
		case (word_cls)
			CL_EMPTY: begin
				if (alpha) word_cls = CL_IDENT;
				else if (digit) word_cls = CL_INT;
				else word_cls = CL_BAD;
			end
			CL_IDENT: begin
				if (!(alpha || digit)) word_cls = CL_BAD;
			end
			CL_INT: begin
				if (c == CH_DOT) word_cls = CL_DOT;
				else if (!digit) word_cls = CL_BAD;
			end
			CL_DOT, CL_FRAC: begin
				if (digit) word_cls = CL_FRAC;
				else word_cls = CL_BAD;
			end
			default: word_cls = CL_BAD;
		endcase
		if (word_len != 8'hFF) begin
			word_len++;
		end
	endfunction

	function void lex_step(logic rt, logic [7:0] c);
		token_exp_t exp_item;
		step_n = 0;
		if (rt) begin
			if (slash_wait) begin
				add_tok(KIND_OPERATOR, 8'd1, CH_SLASH, line_no, slash_col);
			end else begin
				flush_word(col_no);
			end
			reset_lexer();
		end else if (in_cmt) begin
			if (c == CH_NL) begin
				in_cmt = 1'b0;
				bump_line();
			end else begin
				bump_col();
			end
		end else if (slash_wait && c == CH_SLASH) begin
			slash_wait = 1'b0;
			in_cmt = 1'b1;
			bump_col();
		end else begin
			// A lone slash becomes a token only once the next character shows it is not a comment.
			if (slash_wait) begin
				slash_wait = 1'b0;
				add_tok(KIND_OPERATOR, 8'd1, CH_SLASH, line_no, slash_col);
			end
			if (c == CH_NL) begin
				bump_line();
				flush_word('0);
			end else if (c == CH_SLASH) begin
				flush_word(col_no);
				slash_wait = 1'b1;
				slash_col = col_no;
				bump_col();
			end else if (splits_word(c)) begin
				flush_word(col_no);
				if (c != CH_SPACE) begin
					add_tok(delim_token_kind(c), 8'd1, c, line_no, col_no);
				end
				bump_col();
			end else begin
				take_char(c);
				bump_col();
			end
		end
		for (int i = 0; i < step_n; i++) begin
			exp_item.tok = step_toks[i];
			exp_item.last = (i == step_n - 1);
			expected_toks.insert(expected_toks.size(), exp_item);
		end
	endfunction

	function void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		token_exp_t want;
		if (!arst_n) begin
			expected_toks.delete();
			reset_lexer();
			errors = 0;
		end else begin
			if (tok_valid && tok_ready) begin
				if (expected_toks.size() == 0) begin
					errors++;
					$display({"%0t: token transaction with none expected, expected nothing, ",
						"actual kind %0d length %0d"}, $time, token_kind, token_length);
				end else begin
					want = expected_toks.pop_front();
					check_field("token_kind", want.tok.kind, token_kind);
					check_field("token_length", want.tok.length, token_length);
					check_field("delimiter_code", want.tok.delim, delimiter_code);
					check_field("line_number", want.tok.line, line_number);
					check_field("column_number", want.tok.col, column_number);
					check_field("last_of_run", want.last, last_of_run);
				end
			end
			if (in_valid && in_ready) begin
				lex_step(req_type, char_code);
			end
		end
		pending = expected_toks.size();
	end

endmodule

// File: tb/tb_script_lexer_token_classifier_unit.sv
module tb_script_lexer_token_classifier_unit
	import slc_pkg::*;
();

	localparam int STALL_LIMIT = 2000;
	localparam int NUM_RANDOM = 1150;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;
	int   quiet_cycles = 0;
	int   chars_sent;
	logic src_calm;
	logic tok_calm;

	string      kw_list[6] = '{"if", "else", "function", "return", "true", "false"};
	logic [7:0] delims[14] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN,
		CH_SPACE, CH_COMMA, CH_NL, CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LT, CH_GT};

	slc_char_if  src_ch();
	slc_token_if tok_ch();

	script_lexer_token_classifier_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.src(src_ch),
		.tok(tok_ch)
	);

	slc_token_checker token_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(src_ch.valid),
		.in_ready(src_ch.ready),
		.req_type(src_ch.req_type),
		.char_code(src_ch.char_code),
		.tok_valid(tok_ch.valid),
		.tok_ready(tok_ch.ready),
		.token_kind(tok_ch.token_kind),
		.token_length(tok_ch.token_length),
		.delimiter_code(tok_ch.delimiter_code),
		.line_number(tok_ch.line_number),
		.column_number(tok_ch.column_number),
		.last_of_run(tok_ch.last_of_run),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_gap(logic calm);
		if (calm || $urandom_range(0, 1) == 0) begin
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	function automatic logic [7:0] rand_alpha();
		logic [7:0] r;
		r = 8'($urandom_range(0, 25));
		return $urandom_range(0, 1) ? "a" + r : "A" + r;
	endfunction

	task automatic send(logic rt, logic [7:0] c);
		int gap;
		gap = draw_gap(src_calm);
		if (gap > 0) begin
			src_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_ch.valid <= 1'b1;
		src_ch.req_type <= rt;
		src_ch.char_code <= c;
		do @(posedge clk); while (src_ch.ready !== 1'b1);
		chars_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			send(1'b0, s[i]);
		end
	endtask

	initial begin
		int pick;
		int len;
		int alter;
		int start;
		string word;
		logic [7:0] b;
		arst_n = 1'b0;
		src_ch.valid = 1'b0;
		src_ch.req_type = 1'b0;
		src_ch.char_code = 8'd0;
		src_calm = 1'b0;
		chars_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Words before a lone slash and before a comment, odd bytes, a dangling slash at the end.
		send_text("if(x,1.5)a/y//c\n}{<");
		send(1'b0, 8'hFF);
		send(1'b0, 8'h00);
		send_text("-;*> ");
		send(1'b0, CH_SLASH);
		send(1'b1, 8'hA5);

		start = chars_sent;
		while (chars_sent < start + NUM_RANDOM) begin
			if ($urandom_range(0, 40) == 0) begin
				src_calm = ~src_calm;
			end
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				word = kw_list[$urandom_range(0, 5)];
				len = word.len();
				alter = $urandom_range(0, 3);
				if (alter == 0) begin
					len--;
				end
				for (int i = 0; i < len; i++) begin
					send(1'b0, word[i]);
				end
				if (alter == 1) begin
					send(1'b0, rand_alpha());
				end
			end else if (pick < 30) begin
				send(1'b0, rand_alpha());
				len = $urandom_range(0, 7);
				for (int i = 0; i < len; i++) begin
					send(1'b0, $urandom_range(0, 2) == 0 ?
						8'("0" + $urandom_range(0, 9)) : rand_alpha());
				end
			end else if (pick < 42) begin
				len = $urandom_range(1, 5);
				for (int i = 0; i < len; i++) begin
					send(1'b0, 8'("0" + $urandom_range(0, 9)));
				end
				if ($urandom_range(0, 1) == 0) begin
					send(1'b0, CH_DOT);
					len = $urandom_range(0, 3);
					for (int i = 0; i < len; i++) begin
						send(1'b0, 8'("0" + $urandom_range(0, 9)));
					end
				end
			end else if (pick < 62) begin
				send(1'b0, delims[$urandom_range(0, 13)]);
			end else if (pick < 70) begin
				send(1'b0, CH_SPACE);
			end else if (pick < 76) begin
				send(1'b0, CH_NL);
			end else if (pick < 82) begin
				send(1'b0, CH_SLASH);
				send(1'b0, CH_SLASH);
				len = $urandom_range(0, 10);
				for (int i = 0; i < len; i++) begin
					b = 8'($urandom_range(0, 255));
					send(1'b0, b == CH_NL ? "x" : b);
				end
				send(1'b0, CH_NL);
			end else if (pick < 87) begin
				send(1'b0, CH_SLASH);
			end else if (pick < 93) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					send(1'b0, 8'($urandom_range(0, 255)));
				end
			end else if (pick < 97) begin
				send(1'b0, 8'($urandom_range(0, 255)));
			end else begin
				send(1'b1, 8'($urandom_range(0, 255)));
			end
			// Most words are closed off by a delimiter so that they stay apart.
			if ((pick < 42 || (pick >= 87 && pick < 93)) && $urandom_range(0, 3) != 0) begin
				send(1'b0, delims[$urandom_range(0, 13)]);
			end
		end
		send(1'b1, 8'($urandom_range(0, 255)));

		// A word longer than the length field.
		for (int i = 0; i < 300; i++) begin
			send(1'b0, "q");
		end
		send(1'b0, CH_SPACE);
		send_text("x y\nz");
		send(1'b1, 8'd0);

		src_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("** script_lexer_token_classifier_unit: PASSED **");
		end else begin
			$display("** script_lexer_token_classifier_unit: FAILED **");
		end
		$finish;
	end

	initial begin
		int gap;
		tok_ch.ready = 1'b0;
		tok_calm = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 60) == 0) begin
				tok_calm = ~tok_calm;
			end
			gap = draw_gap(tok_calm);
			if (gap > 0) begin
				tok_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tok_ch.ready <= 1'b1;
			do @(posedge clk); while (tok_ch.valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (src_ch.valid && src_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("** script_lexer_token_classifier_unit: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
